// File: sv/atpr_pkg.sv
package atpr_pkg;

    localparam int IN_W            = 16;   // sample and angle field width
    localparam int OFS_W           = 16;   // offset register width
    localparam int CFG_IDX_W       = 8;
    localparam int ANGLE_FRAC_DEF  = 7;
    localparam int CORDIC_STG_DEF  = 16;
    localparam int ACC_FRAC        = 20;   // angle accumulator counts 2^-20 degree
    localparam int IN_SCALE        = 16;
    localparam int TABLE_LEN       = 24;
    localparam int HALF_TURN       = 180;
    localparam int CORDIC_IN_W     = 25;   // covers -x*256 and the 24-bit magnitude
    localparam int CORDIC_W        = 44;
    localparam int ACC_W           = 32;
    localparam int SQ_W            = 48;   // (y^2 + z^2) << 16
    localparam int ROOT_W          = 24;
    localparam int PROD_W          = 2 * IN_W;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET  = CFG_IDX_W'(1);

    // round(atan(2^-i) * 2^20), degrees
    function automatic logic [25:0] atan_q20(input int i);
        logic [25:0] v;
        case (i)
            0:       v = 26'd47185920;
            1:       v = 26'd27855475;
            2:       v = 26'd14718068;
            3:       v = 26'd7471121;
            4:       v = 26'd3750058;
            5:       v = 26'd1876857;
            6:       v = 26'd938658;
            7:       v = 26'd469357;
            8:       v = 26'd234682;
            9:       v = 26'd117342;
            10:      v = 26'd58671;
            11:      v = 26'd29335;
            12:      v = 26'd14668;
            13:      v = 26'd7334;
            14:      v = 26'd3667;
            15:      v = 26'd1833;
            16:      v = 26'd917;
            17:      v = 26'd458;
            18:      v = 26'd229;
            19:      v = 26'd115;
            20:      v = 26'd57;
            21:      v = 26'd29;
            22:      v = 26'd14;
            23:      v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/atpr_if.sv
interface atpr_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [atpr_pkg::IN_W-1:0] accel_x;
    logic signed [atpr_pkg::IN_W-1:0] accel_y;
    logic signed [atpr_pkg::IN_W-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atpr_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [atpr_pkg::IN_W-1:0] pitch_angle;
    logic signed [atpr_pkg::IN_W-1:0] roll_angle;

    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface

interface atpr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [atpr_pkg::CFG_IDX_W-1:0]      index;
    logic [atpr_pkg::OFS_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/atpr_sqrt.sv
module atpr_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_v,
    input  logic signed [atpr_pkg::IN_W-1:0]     i_x,
    input  logic signed [atpr_pkg::IN_W-1:0]     i_y,
    input  logic signed [atpr_pkg::IN_W-1:0]     i_z,
    output logic                                 o_v,
    output logic signed [atpr_pkg::IN_W-1:0]     o_x,
    output logic signed [atpr_pkg::IN_W-1:0]     o_y,
    output logic signed [atpr_pkg::IN_W-1:0]     o_z,
    output logic [atpr_pkg::ROOT_W-1:0]          o_root
);
    import atpr_pkg::*;

    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic [PROD_W-2:0]        r_sq_y;
    logic [PROD_W-2:0]        r_sq_z;
    logic                     r_v0;
    logic signed [IN_W-1:0]   r_x0, r_y0, r_z0;

    logic [SQ_W-1:0]          r_n [0:ROOT_W];
    logic [SQ_W-1:0]          r_r [0:ROOT_W];
    logic                     r_v [0:ROOT_W];
    logic signed [IN_W-1:0]   r_x [0:ROOT_W];
    logic signed [IN_W-1:0]   r_y [0:ROOT_W];
    logic signed [IN_W-1:0]   r_z [0:ROOT_W];

    assign prod_y = i_y * i_y;
    assign prod_z = i_z * i_z;

    // squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_v;
        end
        if (i_en) begin
            r_sq_y <= prod_y[PROD_W-2:0];
            r_sq_z <= prod_z[PROD_W-2:0];
            r_x0   <= i_x;
            r_y0   <= i_y;
            r_z0   <= i_z;
        end
    end

    // sum, scaled by 2^16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_v0;
        end
        if (i_en) begin
            r_n[0] <= {({1'b0, r_sq_y} + {1'b0, r_sq_z}), IN_SCALE'(0)};
            r_r[0] <= '0;
            r_x[0] <= r_x0;
            r_y[0] <= r_y0;
            r_z[0] <= r_z0;
        end
    end

    // one root bit per stage
    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - g));
        logic [SQ_W-1:0] trial;
        assign trial = r_r[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                if (r_n[g] >= trial) begin
                    r_n[g+1] <= r_n[g] - trial;
                    r_r[g+1] <= (r_r[g] >> 1) + BIT;
                end else begin
                    r_n[g+1] <= r_n[g];
                    r_r[g+1] <= r_r[g] >> 1;
                end
                r_x[g+1] <= r_x[g];
                r_y[g+1] <= r_y[g];
                r_z[g+1] <= r_z[g];
            end
        end
    end

    assign o_v    = r_v[ROOT_W];
    assign o_x    = r_x[ROOT_W];
    assign o_y    = r_y[ROOT_W];
    assign o_z    = r_z[ROOT_W];
    assign o_root = r_r[ROOT_W][ROOT_W-1:0];

endmodule

// File: sv/atpr_cordic.sv
module atpr_cordic #(
    parameter int STAGES = atpr_pkg::CORDIC_STG_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_v,
    input  logic signed [atpr_pkg::CORDIC_IN_W-1:0] i_a,
    input  logic signed [atpr_pkg::CORDIC_IN_W-1:0] i_b,
    output logic                                    o_v,
    output logic                                    o_zero,
    output logic signed [atpr_pkg::ACC_W-1:0]       o_acc
);
    import atpr_pkg::*;

    localparam int EXT_W = CORDIC_W - CORDIC_IN_W - IN_SCALE;
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(HALF_TURN) <<< ACC_FRAC;

    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [CORDIC_W-1:0] r_x [0:STAGES];
    logic signed [CORDIC_W-1:0] r_y [0:STAGES];
    logic signed [ACC_W-1:0]    r_z [0:STAGES];
    logic                       r_v [0:STAGES];
    logic                       r_zero [0:STAGES];

    assign xs = {{EXT_W{i_b[CORDIC_IN_W-1]}}, i_b, IN_SCALE'(0)};
    assign ys = {{EXT_W{i_a[CORDIC_IN_W-1]}}, i_a, IN_SCALE'(0)};

    // fold the left half-plane onto the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
        end
        if (i_en) begin
            r_zero[0] <= (i_a == '0) && (i_b == '0);
            if (i_b[CORDIC_IN_W-1]) begin
                r_x[0] <= -xs;
                r_y[0] <= -ys;
                r_z[0] <= i_a[CORDIC_IN_W-1] ? -HALF_ACC : HALF_ACC;
            end else begin
                r_x[0] <= xs;
                r_y[0] <= ys;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_q20(g));
        logic signed [CORDIC_W-1:0] dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (!r_y[g][CORDIC_W-1]) begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + ANG;
                end else begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - ANG;
                end
            end
        end
    end

    assign o_v    = r_v[STAGES];
    assign o_zero = r_zero[STAGES];
    assign o_acc  = r_z[STAGES];

endmodule

// File: sv/accel_tilt_pitch_roll_unit.sv
// Pitch and roll from one three-axis accelerometer sample. Takes one sample per
// clock while the skid entry is empty and gives one result per sample, in order.
// Each sample passes the squares and their sum, the bit-per-stage square root of
// the magnitude, the vector fold and the CORDIC iterations, pitch and roll running
// side by side, before it reaches the output register. A two-entry output stage lets
// the block keep taking samples while one result waits; input ready drops only
// when both entries are full. Angles are in 1/2^ANGLE_FRAC_BITS degree,
// offset-corrected and clamped to +/-180 degrees. Write the offsets only while no
// sample is in flight.
module accel_tilt_pitch_roll_unit #(
    parameter int ANGLE_FRAC_BITS = atpr_pkg::ANGLE_FRAC_DEF,
    parameter int CORDIC_STAGES   = atpr_pkg::CORDIC_STG_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atpr_in_if.sink           i_in,
    atpr_cfg_if.sink          i_cfg,
    atpr_out_if.source        o_out
);
    import atpr_pkg::*;

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (SH - 1);
    localparam logic signed [ACC_W-1:0] LIM = ACC_W'(HALF_TURN) <<< ANGLE_FRAC_BITS;

    function automatic logic [IN_W-1:0] finish(input logic signed [ACC_W-1:0] acc,
                                               input logic zero,
                                               input logic signed [OFS_W-1:0] ofs);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] v;
        a = zero ? '0 : acc;
        v = ((a + RND) >>> SH) - ACC_W'(ofs);
        if (v > LIM) begin
            v = LIM;
        end
        if (v < -LIM) begin
            v = -LIM;
        end
        return v[IN_W-1:0];
    endfunction

    logic                      en;
    logic signed [OFS_W-1:0]   r_pitch_ofs;
    logic signed [OFS_W-1:0]   r_roll_ofs;

    logic                      sq_v;
    logic signed [IN_W-1:0]    sq_x, sq_y, sq_z;
    logic [ROOT_W-1:0]         sq_root;
    logic signed [IN_W:0]      neg_x;
    logic signed [CORDIC_IN_W-1:0] pitch_a, pitch_b, roll_a, roll_b;

    logic                      pitch_v, pitch_zero, roll_v, roll_zero;
    logic signed [ACC_W-1:0]   pitch_acc, roll_acc;
    logic [IN_W-1:0]           pitch_fin, roll_fin;
    logic                      push, pop;

    logic                      r_out_v, r_sk_v;
    logic [IN_W-1:0]           r_out_pitch, r_out_roll, r_sk_pitch, r_sk_roll;

    // the whole pipeline holds while the skid entry is occupied
    assign en         = !r_sk_v;
    assign i_in.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_ofs <= '0;
            r_roll_ofs  <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_PITCH_OFFSET) begin
                r_pitch_ofs <= i_cfg.data;
            end else if (i_cfg.index == REG_ROLL_OFFSET) begin
                r_roll_ofs <= i_cfg.data;
            end
        end
    end

    atpr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (i_in.valid),
        .i_x     (i_in.accel_x),
        .i_y     (i_in.accel_y),
        .i_z     (i_in.accel_z),
        .o_v     (sq_v),
        .o_x     (sq_x),
        .o_y     (sq_y),
        .o_z     (sq_z),
        .o_root  (sq_root)
    );

    assign neg_x   = -{sq_x[IN_W-1], sq_x};
    assign pitch_a = {neg_x, 8'b0};
    assign pitch_b = {1'b0, sq_root};
    assign roll_a  = {{(CORDIC_IN_W-IN_W){sq_y[IN_W-1]}}, sq_y};
    assign roll_b  = {{(CORDIC_IN_W-IN_W){sq_z[IN_W-1]}}, sq_z};

    atpr_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (sq_v),
        .i_a     (pitch_a),
        .i_b     (pitch_b),
        .o_v     (pitch_v),
        .o_zero  (pitch_zero),
        .o_acc   (pitch_acc)
    );

    atpr_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (sq_v),
        .i_a     (roll_a),
        .i_b     (roll_b),
        .o_v     (roll_v),
        .o_zero  (roll_zero),
        .o_acc   (roll_acc)
    );

    assign pitch_fin = finish(pitch_acc, pitch_zero, r_pitch_ofs);
    assign roll_fin  = finish(roll_acc, roll_zero, r_roll_ofs);

    assign push = en && pitch_v && roll_v;
    assign pop  = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (pop) begin
                r_sk_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_v || pop) begin
                r_out_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (pop) begin
                r_out_pitch <= r_sk_pitch;
                r_out_roll  <= r_sk_roll;
            end
        end else if (push) begin
            if (!r_out_v || pop) begin
                r_out_pitch <= pitch_fin;
                r_out_roll  <= roll_fin;
            end else begin
                r_sk_pitch <= pitch_fin;
                r_sk_roll  <= roll_fin;
            end
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.pitch_angle = r_out_pitch;
    assign o_out.roll_angle  = r_out_roll;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pitch_v == roll_v)
        else $error("pitch and roll pipelines out of step");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_v && !o_out.ready) |=> r_sk_v)
        else $error("result lost while output stalled");

endmodule

// File: dv/testbench.sv
module testbench;
    import atpr_pkg::*;

    localparam int FRAC      = ANGLE_FRAC_DEF;
    localparam int STAGES    = CORDIC_STG_DEF;
    localparam int ROUND_SH  = ACC_FRAC - FRAC;
    localparam longint LIMIT_ANGLE = longint'(HALF_TURN) << FRAC;
    localparam int DRAIN_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(255);

    // degrees in 2^-20 units, atan(2^-i)
    localparam longint ATAN_STEP [TABLE_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        logic signed [IN_W-1:0] pitch;
        logic signed [IN_W-1:0] roll;
    } t_tilt;

    logic i_clk;
    logic i_rst_n;

    atpr_in_if  in_if ();
    atpr_out_if out_if ();
    atpr_cfg_if cfg_if ();

    accel_tilt_pitch_roll_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_out   (out_if.source)
    );

    t_tilt                  expected_tilt [$];
    logic signed [OFS_W-1:0] pitch_ofs;
    logic signed [OFS_W-1:0] roll_ofs;
    int                     errors;
    int                     quiet_cycles;
    int                     hold_request;
    bit                     sender_gaps;
    bit                     receiver_gaps;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // angle of (b, a) in 2^-20 degree units
    function automatic longint vector_angle(longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (a == 0 && b == 0) return 0;
        x = b <<< IN_SCALE;
        y = a <<< IN_SCALE;
        if (x < 0) begin
            z = (y >= 0) ? (longint'(HALF_TURN) <<< ACC_FRAC)
                         : -(longint'(HALF_TURN) <<< ACC_FRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [IN_W-1:0] corrected_angle(longint acc,
                                                               logic signed [OFS_W-1:0] ofs);
        longint v;
        v = (acc + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        v = v - longint'(ofs);
        if (v > LIMIT_ANGLE) v = LIMIT_ANGLE;
        if (v < -LIMIT_ANGLE) v = -LIMIT_ANGLE;
        return v[IN_W-1:0];
    endfunction

    function automatic t_tilt predict_tilt(logic signed [IN_W-1:0] x,
                                           logic signed [IN_W-1:0] y,
                                           logic signed [IN_W-1:0] z);
        t_tilt  t;
        longint ax;
        longint ay;
        longint az;
        longint mag8;
        ax = longint'(x);
        ay = longint'(y);
        az = longint'(z);
        mag8 = longint'(int_sqrt(longint'(ay * ay + az * az) << 16));
        t.pitch = corrected_angle(vector_angle(-ax * 256, mag8), pitch_ofs);
        t.roll  = corrected_angle(vector_angle(ay, az), roll_ofs);
        return t;
    endfunction

    task automatic send_sample(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                               logic signed [IN_W-1:0] z);
        int n;
        in_if.valid   <= 1'b1;
        in_if.accel_x <= x;
        in_if.accel_y <= y;
        in_if.accel_z <= z;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_tilt.push_back(predict_tilt(x, y, z));
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_random_sample();
        logic signed [IN_W-1:0] v [3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1, 2, 3: v[k] = IN_W'($urandom);
                4, 5:       v[k] = IN_W'($signed(IN_W'($urandom_range(0, 600))) - 300);
                6:          v[k] = ($urandom_range(0, 1) == 0) ? '0 : IN_W'($urandom);
                7:          v[k] = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
                default:    v[k] = (k == 2)
                                   ? IN_W'($urandom_range(8000, 20000))
                                   : IN_W'($signed(IN_W'($urandom_range(0, 2000))) - 1000);
            endcase
        end
        send_sample(v[0], v[1], v[2]);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_PITCH_OFFSET: pitch_ofs = value;
            REG_ROLL_OFFSET:  roll_ofs  = value;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold until every result is back and the pipe is empty
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tilt.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_axis_extremes();
        send_sample('0, '0, '0);
        send_sample(16'sh7fff, '0, '0);
        send_sample(16'sh8000, '0, '0);
        send_sample('0, 16'sh7fff, '0);
        send_sample('0, 16'sh8000, '0);
        send_sample('0, '0, 16'sh7fff);
        send_sample('0, '0, 16'sh8000);
        send_sample('0, '0, -16'sd1);
        send_sample('0, -16'sd1, -16'sd1);
        send_sample('0, 16'sd1, -16'sd1);
        send_sample(16'sd5, '0, '0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(-16'sd1, 16'sh7fff, 16'sh8000);
        send_sample(16'sd100, -16'sd200, 16'sd16000);
        drain();
    endtask

    task automatic test_offsets();
        logic [OFS_W-1:0] settings [6] = '{16'd23040, -16'sd23040, 16'h8000, 16'h7fff,
                                           16'd0, 16'd128};
        for (int s = 0; s < 6; s++) begin
            write_reg(REG_PITCH_OFFSET, settings[s]);
            write_reg(REG_ROLL_OFFSET, settings[5 - s]);
            send_sample('0, '0, '0);
            send_sample('0, '0, 16'sh8000);
            send_sample(16'sh8000, '0, '0);
            send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
            drain();
        end
        // writes to unused indexes must leave the offsets alone
        write_reg(REG_PITCH_OFFSET, -16'sd300);
        write_reg(REG_ROLL_OFFSET, 16'd777);
        write_reg(REG_UNUSED_LO, 16'hffff);
        write_reg(REG_UNUSED_HI, 16'h1234);
        send_sample('0, 16'sd1000, 16'sd1000);
        send_sample(-16'sd1000, '0, 16'sd1000);
        drain();
    endtask

    task automatic test_random_samples();
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_PITCH_OFFSET, OFS_W'($urandom_range(0, 46080) - 23040));
            write_reg(REG_ROLL_OFFSET, OFS_W'($urandom));
            sender_gaps   = (p != 2);
            receiver_gaps = (p != 2);
            repeat (80) send_random_sample();
            drain();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(REG_PITCH_OFFSET, 16'd0);
        write_reg(REG_ROLL_OFFSET, 16'd0);
        sender_gaps  = 1'b0;
        hold_request = 400;
        repeat (100) send_random_sample();
        sender_gaps  = 1'b1;
        drain();
    endtask

    // sink side: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tilt exp_t;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_tilt.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pitch=%0d roll=%0d", $time,
                         out_if.pitch_angle, out_if.roll_angle);
            end else begin
                exp_t = expected_tilt.pop_front();
                if (out_if.pitch_angle !== exp_t.pitch) begin
                    errors++;
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             exp_t.pitch, out_if.pitch_angle);
                end
                if (out_if.roll_angle !== exp_t.roll) begin
                    errors++;
                    $display("%0t: roll expected %0d actual %0d", $time,
                             exp_t.roll, out_if.roll_angle);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL accel_tilt_pitch_roll_unit");
            $finish;
        end
    end

    initial begin
        errors        = 0;
        quiet_cycles  = 0;
        hold_request  = 0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        pitch_ofs     = '0;
        roll_ofs      = '0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.accel_x = '0;
        in_if.accel_y = '0;
        in_if.accel_z = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axis_extremes();
        test_offsets();
        test_random_samples();
        test_backpressure();

        if (errors == 0 && expected_tilt.size() == 0) begin
            $display("PASS accel_tilt_pitch_roll_unit");
        end else begin
            $display("FAIL accel_tilt_pitch_roll_unit");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/atpr_pkg.sv
sv/atpr_if.sv
sv/atpr_sqrt.sv
sv/atpr_cordic.sv
sv/accel_tilt_pitch_roll_unit.sv
dv/testbench.sv
